// File: hw/rtl/windowed_rgb_gray_histogram_unit_macros.svh
// assertion macros for the windowed rgb/gray histogram unit
// used by files that assert; expects clk and rst_n in scope
`ifndef WINDOWED_RGB_GRAY_HISTOGRAM_UNIT_MACROS_SVH
`define WINDOWED_RGB_GRAY_HISTOGRAM_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WRGH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WRGH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WRGH_ASSERT_SAME(lbl, ante, cons)
`define WRGH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/wrgh_pkg.sv
// shared types and constants of the windowed rgb/gray histogram unit
// no dependencies
`default_nettype none
package wrgh_pkg;
    localparam int BINS      = 256;
    localparam int BIN_BITS  = 8;
    localparam int NORM_BITS = 16;
    localparam int OUT_BITS  = 22;
    localparam int LANES     = 4;
    localparam logic [OUT_BITS-1:0] OUT_MAX = 22'h3FFFFF;

    // floor(s/3) for s <= 765 as (s * 683) >> 11
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] CFG_GRAY_LOW   = 2'd0;
    localparam logic [1:0] CFG_GRAY_HIGH  = 2'd1;
    localparam logic [1:0] CFG_NORM_SCALE = 2'd2;

    localparam logic [7:0]  GRAY_LOW_RST   = 8'd20;
    localparam logic [7:0]  GRAY_HIGH_RST  = 8'd222;
    localparam logic [15:0] NORM_SCALE_RST = 16'd15000;

    typedef struct packed {
        logic capture;
        logic sweep_clr;
        logic mem_rd;
        logic rd_bin;
        logic pix_wr;
        logic ch_clr;
        logic mul_load;
        logic div_step;
        logic q_store;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic div_last;
        logic ch_last;
        logic out_busy;
    } sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/wrgh_ctrl.sv
// controller state machine of the histogram unit
// depends on wrgh_pkg
`default_nettype none
module wrgh_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    mode,
    output wrgh_pkg::cmd_t     cmd,
    input  wire wrgh_pkg::sts_t sts
);
    import wrgh_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_PIX_RD = 9'b000000100,
        ST_PIX_WR = 9'b000001000,
        ST_BIN_RD = 9'b000010000,
        ST_MUL    = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_STORE  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_clr = 1'b1;
                if (sts.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (mode)
                        MODE_PIXEL: state_next = ST_PIX_RD;
                        MODE_READ:  state_next = ST_BIN_RD;
                        MODE_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR:
            begin
                cmd.pix_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BIN_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_bin = 1'b1;
                cmd.ch_clr = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.q_store = 1'b1;
                state_next  = sts.ch_last ? ST_OUT : ST_MUL;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// File: hw/rtl/wrgh_datapath.sv
// datapath of the histogram unit: config, bin memories, divider, result register
// depends on wrgh_pkg and the assertion macro header
`default_nettype none
`include "windowed_rgb_gray_histogram_unit_macros.svh"
module wrgh_datapath #(
    parameter int COUNT_BITS = 22
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire wrgh_pkg::cmd_t                 cmd,
    output wrgh_pkg::sts_t                      sts,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [15:0]                    cfg_data,
    input  wire logic [7:0]                     red,
    input  wire logic [7:0]                     green,
    input  wire logic [7:0]                     blue,
    input  wire logic [7:0]                     bin_index,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          bin_out,
    output logic [wrgh_pkg::NORM_BITS-1:0]      gray_norm,
    output logic [wrgh_pkg::NORM_BITS-1:0]      red_norm,
    output logic [wrgh_pkg::NORM_BITS-1:0]      green_norm,
    output logic [wrgh_pkg::NORM_BITS-1:0]      blue_norm,
    output logic                                no_pixels,
    output logic [wrgh_pkg::OUT_BITS-1:0]       counted_pixels
);
    import wrgh_pkg::*;

    localparam int P  = COUNT_BITS + NORM_BITS;
    localparam int SB = $clog2(P);
    localparam int TW = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam logic [SB-1:0] STEP_LAST = SB'(P - 1);

    // configuration
    logic [7:0]  gray_low_reg, gray_high_reg;
    logic [15:0] norm_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_low_reg   <= GRAY_LOW_RST;
            gray_high_reg  <= GRAY_HIGH_RST;
            norm_scale_reg <= NORM_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRAY_LOW:   gray_low_reg   <= cfg_data[7:0];
                CFG_GRAY_HIGH:  gray_high_reg  <= cfg_data[7:0];
                CFG_NORM_SCALE: norm_scale_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // input capture, gray by reciprocal multiply
    logic [9:0]  rgb_sum;
    logic [19:0] gray_prod;
    logic [7:0]  gray_val;
    logic [7:0]  addr_reg [LANES];
    logic [7:0]  bin_reg;
    logic        win_reg;

    assign rgb_sum   = 10'(red) + 10'(green) + 10'(blue);
    assign gray_prod = 20'(rgb_sum) * 20'(DIV3_MUL);
    assign gray_val  = gray_prod[DIV3_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg[0] <= gray_val;
            addr_reg[1] <= red;
            addr_reg[2] <= green;
            addr_reg[3] <= blue;
            bin_reg     <= bin_index;
            win_reg     <= (gray_val > gray_low_reg) && (gray_val < gray_high_reg);
        end
    end

    // clearing sweep address
    logic [BIN_BITS-1:0] sweep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.sweep_clr)
            sweep_reg <= sweep_reg + 1'b1;
    end

    // pixel total
    logic [COUNT_BITS-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (cmd.sweep_clr)
            total_reg <= '0;
        else if (cmd.pix_wr && win_reg && (total_reg != '1))
            total_reg <= total_reg + 1'b1;
    end

    // four bin memories, one per histogram
    logic [COUNT_BITS-1:0] rd_data [LANES];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [COUNT_BITS-1:0] mem [BINS];
        logic [BIN_BITS-1:0]   wr_addr, rd_addr;
        logic [COUNT_BITS-1:0] wr_data;
        logic                  wr_en;

        assign wr_addr = cmd.sweep_clr ? sweep_reg : addr_reg[l];
        assign rd_addr = cmd.rd_bin ? bin_reg : addr_reg[l];
        assign wr_en   = cmd.sweep_clr || (cmd.pix_wr && win_reg);
        assign wr_data = cmd.sweep_clr ? '0 :
                         ((rd_data[l] == '1) ? rd_data[l] : rd_data[l] + 1'b1);

        always_ff @(posedge clk)
        begin
            if (wr_en)
                mem[wr_addr] <= wr_data;
            if (cmd.mem_rd)
                rd_data[l] <= mem[rd_addr];
        end
    end

    // channel sequencing
    logic [1:0] ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch_reg <= '0;
        else if (cmd.ch_clr)
            ch_reg <= '0;
        else if (cmd.q_store)
            ch_reg <= ch_reg + 1'b1;
    end

    // restoring divider, one quotient bit per cycle
    logic [P-1:0]            dvd_reg;
    logic [COUNT_BITS:0]     rem_reg;
    logic [SB-1:0]           step_reg;
    logic [COUNT_BITS:0]     rem_shift;
    logic [COUNT_BITS+1:0]   trial;

    assign rem_shift = {rem_reg[COUNT_BITS-1:0], dvd_reg[P-1]};
    assign trial     = {1'b0, rem_shift} - {2'b0, total_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            dvd_reg  <= P'(rd_data[ch_reg]) * P'(norm_scale_reg);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + 1'b1;
            if (!trial[COUNT_BITS+1])
            begin
                rem_reg <= trial[COUNT_BITS:0];
                dvd_reg <= {dvd_reg[P-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                dvd_reg <= {dvd_reg[P-2:0], 1'b0};
            end
        end
    end

    // quotient store with clamp, zero when no pixels
    logic [NORM_BITS-1:0] norm_reg [LANES];
    logic [NORM_BITS-1:0] q_clamped;

    assign q_clamped = (total_reg == '0) ? '0 :
                       ((|dvd_reg[P-1:NORM_BITS]) ? '1 : dvd_reg[NORM_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.q_store)
            norm_reg[ch_reg] <= q_clamped;
    end

    // result register
    logic [TW-1:0]       tot_ext;
    logic [OUT_BITS-1:0] tot_sat;
    logic                out_valid_reg;

    assign tot_ext = TW'(total_reg);
    assign tot_sat = (tot_ext > TW'(OUT_MAX)) ? OUT_MAX : tot_ext[OUT_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            bin_out        <= bin_reg;
            gray_norm      <= norm_reg[0];
            red_norm       <= norm_reg[1];
            green_norm     <= norm_reg[2];
            blue_norm      <= norm_reg[3];
            no_pixels      <= (total_reg == '0);
            counted_pixels <= tot_sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sts.sweep_last = (sweep_reg == '1);
    assign sts.div_last   = (step_reg == STEP_LAST);
    assign sts.ch_last    = (ch_reg == 2'(LANES - 1));
    assign sts.out_busy   = out_valid_reg;

    `WRGH_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, !out_valid_reg)
    `WRGH_ASSERT_SAME(a_write_after_read, cmd.pix_wr, $past(cmd.mem_rd))
    `WRGH_ASSERT_NEXT(a_total_monotonic, !cmd.sweep_clr, total_reg >= $past(total_reg))
endmodule
`default_nettype wire

// File: hw/rtl/windowed_rgb_gray_histogram_unit.sv
// Windowed RGB/gray histogram unit: top level joining controller and datapath
// depends on wrgh_pkg, wrgh_ctrl and wrgh_datapath
//
// Usage:
//  - input channel (in_valid/in_ready) carries one item per transaction:
//    mode 0 pixel, mode 1 bin read, mode 2 clear, mode 3 ignored
//  - a pixel is read and then increment-written in the four bin memories
//  - a bin read produces one result transaction: four restoring divisions of
//    one quotient bit per cycle on a single shared divider, plus the multiply
//    and store steps
//  - a clear sweeps all 256 bins, one per cycle
//  - after reset the same clearing sweep runs before in_ready rises;
//    configuration writes are taken during it
//  - results sit in an output register; while the receiver stalls, pixels and
//    clears still go on, and a second read waits for the register to empty
//  - the configuration channel is always ready
`default_nettype none
module windowed_rgb_gray_histogram_unit #(
    parameter int COUNT_BITS = 22
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [15:0]                    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     mode,
    input  wire logic [7:0]                     red,
    input  wire logic [7:0]                     green,
    input  wire logic [7:0]                     blue,
    input  wire logic [7:0]                     bin_index,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          bin_out,
    output logic [wrgh_pkg::NORM_BITS-1:0]      gray_norm,
    output logic [wrgh_pkg::NORM_BITS-1:0]      red_norm,
    output logic [wrgh_pkg::NORM_BITS-1:0]      green_norm,
    output logic [wrgh_pkg::NORM_BITS-1:0]      blue_norm,
    output logic                                no_pixels,
    output logic [wrgh_pkg::OUT_BITS-1:0]       counted_pixels
);
    import wrgh_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wrgh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .cmd      (cmd),
        .sts      (sts)
    );

    wrgh_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .bin_index      (bin_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bin_out        (bin_out),
        .gray_norm      (gray_norm),
        .red_norm       (red_norm),
        .green_norm     (green_norm),
        .blue_norm      (blue_norm),
        .no_pixels      (no_pixels),
        .counted_pixels (counted_pixels)
    );
endmodule
`default_nettype wire
